// ===== rtl/spm_pkg.sv =====
`default_nettype none
package spm_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int SLOT_BYTES   = 4;
    localparam int MAX_SLOTS    = 512;

    localparam int PAGE_AW = $clog2(PAGE_BYTES);
    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int LEN_W   = 13;
    localparam int BIX_W   = 12;
    localparam int CALC_W  = 16;
    localparam int SUM_W   = 24;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_GET       = 3'd1,
        CMD_UPDATE    = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_RAW_WRITE = 3'd4,
        CMD_RAW_CLEAR = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_RANGE   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_LOOK,
        S_GETB,
        S_SRCH,
        S_DECIDE,
        S_PF,
        S_PFCHK,
        S_CRST,
        S_CSCAN,
        S_CSEL,
        S_CRD,
        S_CWR,
        S_CUPD,
        S_POSTC,
        S_PLACE,
        S_RD0,
        S_LEN0,
        S_FIRST
    } t_state;

    typedef struct packed {
        logic               we;
        logic [PAGE_AW-1:0] addr;
        logic [7:0]         data;
    } t_pg_wr;

endpackage
`default_nettype wire

// ===== rtl/spm_page_ram.sv =====
`default_nettype none
module spm_page_ram (
    input  wire                          i_clk,
    input  wire spm_pkg::t_pg_wr         i_wr,
    input  wire [spm_pkg::PAGE_AW-1:0]   i_raddr,
    output logic [7:0]                   o_rdata
);
    import spm_pkg::*;

    logic [7:0] mem [PAGE_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/slotted_page_manager_core.sv =====
`default_nettype none
// Channel  | Handshake             | Fields
// command  | start && !busy        | i_command i_slot_id i_tuple_length i_data_byte
//          |                       | i_byte_index i_byte_last
// result   | o_strobe (one cycle)  | o_status o_result_slot o_read_byte o_stored_length
//          |                       | o_free_bytes o_done_res
// Data beats of a write after its first are taken in S_IDLE; busy stays low between them.
// A first beat takes a slot read, then scans of the slot table (for the lowest dead slot,
// the free sum and each compaction pick, plus S_CRST and S_CSEL per pick) and a read and
// a write per moved byte. Get passes S_LOOK and S_GETB (only S_LOOK when refused),
// remove and clear only S_LOOK. One result per beat, in the cycle after it ends.
// After reset a pass over all 512 slots clears the live marks; busy stays high meanwhile.
// The receiver cannot stall.
module slotted_page_manager_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [2:0]                   i_command,
    input  wire [spm_pkg::SLOT_W-1:0]   i_slot_id,
    input  wire [spm_pkg::LEN_W-1:0]    i_tuple_length,
    input  wire [7:0]                   i_data_byte,
    input  wire [spm_pkg::BIX_W-1:0]    i_byte_index,
    input  wire                         i_byte_last,
    output logic                        o_strobe,
    output logic [1:0]                  o_status,
    output logic [spm_pkg::SLOT_W-1:0]  o_result_slot,
    output logic [7:0]                  o_read_byte,
    output logic [spm_pkg::LEN_W-1:0]   o_stored_length,
    output logic [spm_pkg::LEN_W-1:0]   o_free_bytes,
    output logic                        o_done_res
);
    import spm_pkg::*;

    localparam int OL_W = 2 * LEN_W;

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx, r_used, n_used, r_dead, n_dead, r_add, n_add;
    logic [LEN_W-1:0]  r_fp, n_fp, r_wr_base, n_wr_base, r_wr_len, n_wr_len;
    logic [LEN_W-1:0]  r_cursor, n_cursor, r_stlen, n_stlen;
    logic [SLOT_W-1:0] r_wr_slot, n_wr_slot;
    t_status           r_wr_code, n_wr_code;
    logic              r_wr_busy, n_wr_busy, r_failed, n_failed;
    t_cmd              r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_sid, n_sid, r_s, n_s, r_best, n_best, r_prev_idx, n_prev_idx;
    logic [LEN_W-1:0]  r_len, n_len, r_slen, n_slen;
    logic [BIX_W-1:0]  r_bix, n_bix;
    logic [7:0]        r_dat, n_dat;
    logic              r_last, n_last, r_valid, n_valid, r_snone, n_snone;
    logic [CALC_W-1:0] r_need, n_need;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [LEN_W-1:0]  r_cur, n_cur, r_best_off, n_best_off, r_best_len, n_best_len;
    logic [LEN_W-1:0]  r_prev_off, n_prev_off, r_k, n_k;
    logic              r_found, n_found, r_have_prev, n_have_prev;

    logic [OL_W-1:0]   ol_mem [MAX_SLOTS];
    logic              lv_mem [MAX_SLOTS];
    logic [OL_W-1:0]   r_ol_q;
    logic              r_lv_q;
    logic              ol_we, lv_we, lv_wdata;
    logic [SLOT_W-1:0] ol_waddr, lv_waddr;
    logic [OL_W-1:0]   ol_wdata;

    t_pg_wr             pg_wr;
    logic [PAGE_AW-1:0] pg_raddr;
    logic [7:0]         pg_rdata;

    logic               e_emit, e_done;
    t_status            e_status;
    logic [SLOT_W-1:0]  e_slot;
    logic [7:0]         e_byte;
    logic [LEN_W-1:0]   e_len;

    logic [CALC_W-1:0]  w_hdr_used, w_need, w_fs_raw;
    logic [LEN_W-1:0]   w_free, q_off, q_len, w_newcur;
    logic [CNT_W-1:0]   w_add;
    logic [LEN_W:0]     w_wr_addr, w_rd_addr;
    logic               w_valid, w_fs_ok, w_fs_ok_r, w_cand, w_skip_hit;
    logic [SLOT_W-1:0]  w_place_s;

    spm_page_ram u_page (
        .i_clk   (i_clk),
        .i_wr    (pg_wr),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    assign q_off      = r_ol_q[OL_W-1:LEN_W];
    assign q_len      = r_ol_q[LEN_W-1:0];
    assign w_hdr_used = CALC_W'(HEADER_BYTES) + CALC_W'(r_used) * CALC_W'(SLOT_BYTES);
    assign w_fs_raw   = CALC_W'(r_fp) - w_hdr_used;
    assign w_free     = (CALC_W'(r_fp) < w_hdr_used) ? '0 : w_fs_raw[LEN_W-1:0];
    assign w_valid    = (CNT_W'(r_sid) < r_used) && r_lv_q;
    assign w_add      = (CNT_W'(r_sid) >= r_used) ? (CNT_W'(r_sid) + 1'b1 - r_used) : '0;
    assign w_fs_ok    = CALC_W'(r_fp) >= (w_need + w_hdr_used);
    assign w_fs_ok_r  = CALC_W'(r_fp) >= (r_need + w_hdr_used);
    assign w_newcur   = r_cur - r_best_len;
    assign w_skip_hit = r_valid && (r_idx[SLOT_W-1:0] == r_sid);
    assign w_cand     = r_lv_q && (!r_have_prev || (q_off < r_prev_off)
                        || ((q_off == r_prev_off) && (r_idx[SLOT_W-1:0] > r_prev_idx)));
    assign w_wr_addr  = {1'b0, r_wr_base} + {1'b0, r_cursor};
    assign w_rd_addr  = {1'b0, r_ol_q[OL_W-1:LEN_W]} + (LEN_W+1)'(r_bix);

    always_comb begin
        case (r_cmd)
            CMD_INSERT:    w_need = CALC_W'(r_len) + (r_snone ? CALC_W'(SLOT_BYTES) : '0);
            CMD_RAW_WRITE: w_need = CALC_W'(w_add) * CALC_W'(SLOT_BYTES) + CALC_W'(r_len);
            default:       w_need = CALC_W'(r_len);
        endcase
        if (r_cmd == CMD_INSERT) begin
            w_place_s = r_snone ? r_used[SLOT_W-1:0] : r_s;
        end else begin
            w_place_s = r_sid;
        end
    end

    always_comb begin
        n_state = r_state;     n_idx = r_idx;         n_used = r_used;
        n_dead = r_dead;       n_add = r_add;         n_fp = r_fp;
        n_wr_base = r_wr_base; n_wr_len = r_wr_len;   n_cursor = r_cursor;
        n_stlen = r_stlen;     n_wr_slot = r_wr_slot; n_wr_code = r_wr_code;
        n_wr_busy = r_wr_busy; n_failed = r_failed;   n_cmd = r_cmd;
        n_sid = r_sid;         n_s = r_s;             n_best = r_best;
        n_prev_idx = r_prev_idx; n_len = r_len;
        n_slen = r_slen;       n_bix = r_bix;         n_dat = r_dat;
        n_last = r_last;       n_valid = r_valid;     n_snone = r_snone;
        n_need = r_need;       n_sum = r_sum;         n_cur = r_cur;
        n_best_off = r_best_off; n_best_len = r_best_len; n_prev_off = r_prev_off;
        n_k = r_k;             n_found = r_found;     n_have_prev = r_have_prev;
        ol_we = 1'b0;  ol_waddr = r_sid;  ol_wdata = '0;
        lv_we = 1'b0;  lv_waddr = r_sid;  lv_wdata = 1'b0;
        pg_wr = '0;    pg_raddr = '0;
        e_emit = 1'b0; e_status = STAT_OK; e_slot = '0; e_byte = '0; e_len = '0;
        e_done = 1'b0;

        case (r_state)
            S_CLR: begin
                lv_we    = 1'b1;
                lv_waddr = r_idx[SLOT_W-1:0];
                if (r_idx == CNT_W'(MAX_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (r_wr_busy) begin
                        if (!r_failed && (r_cursor < r_wr_len)) begin
                            if (w_wr_addr < (LEN_W+1)'(PAGE_BYTES)) begin
                                pg_wr = '{we: 1'b1, addr: w_wr_addr[PAGE_AW-1:0],
                                          data: i_data_byte};
                            end
                            n_cursor = r_cursor + 1'b1;
                        end
                        e_emit   = 1'b1;
                        e_status = r_wr_code;
                        e_slot   = r_wr_slot;
                        e_len    = r_failed ? r_stlen : r_wr_len;
                        e_done   = i_byte_last;
                        if (i_byte_last) begin
                            n_wr_busy = 1'b0;
                            n_cursor  = '0;
                            n_failed  = 1'b0;
                        end
                    end else begin
                        n_cmd  = t_cmd'(i_command);
                        n_sid  = i_slot_id;
                        n_len  = i_tuple_length;
                        n_bix  = i_byte_index;
                        n_dat  = i_data_byte;
                        n_last = i_byte_last;
                        case (t_cmd'(i_command))
                            CMD_INSERT, CMD_GET, CMD_UPDATE, CMD_REMOVE, CMD_RAW_WRITE,
                            CMD_RAW_CLEAR: begin
                                n_idx   = CNT_W'(i_slot_id);
                                n_state = S_LOOK;
                            end
                            default: begin
                                e_emit = 1'b1;
                                e_done = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_LOOK: begin
                n_valid = w_valid;
                n_slen  = q_len;
                n_state = S_IDLE;
                case (r_cmd)
                    CMD_RAW_CLEAR, CMD_REMOVE: begin
                        e_emit = 1'b1;
                        e_slot = r_sid;
                        e_done = 1'b1;
                        if (w_valid) begin
                            lv_we  = 1'b1;
                            n_dead = r_dead + 1'b1;
                        end else if (r_cmd == CMD_REMOVE) begin
                            e_status = STAT_INVALID;
                        end
                    end
                    CMD_GET: begin
                        e_slot = r_sid;
                        e_done = 1'b1;
                        if (!w_valid) begin
                            e_emit   = 1'b1;
                            e_status = STAT_INVALID;
                        end else if (LEN_W'(r_bix) >= q_len) begin
                            e_emit   = 1'b1;
                            e_status = STAT_RANGE;
                            e_len    = q_len;
                        end else if (w_rd_addr < (LEN_W+1)'(PAGE_BYTES)) begin
                            pg_raddr = w_rd_addr[PAGE_AW-1:0];
                            n_state  = S_GETB;
                        end else begin
                            e_emit = 1'b1;
                            e_len  = q_len;
                        end
                    end
                    CMD_INSERT, CMD_UPDATE, CMD_RAW_WRITE: begin
                        n_wr_busy = 1'b1;
                        n_cursor  = '0;
                        n_failed  = 1'b0;
                        n_wr_code = STAT_OK;
                        n_wr_slot = r_sid;
                        n_wr_len  = r_len;
                        if (r_cmd == CMD_INSERT) begin
                            if (r_dead != '0) begin
                                n_idx   = '0;
                                n_state = S_SRCH;
                            end else begin
                                n_snone = 1'b1;
                                n_state = S_DECIDE;
                            end
                        end else if ((r_cmd == CMD_UPDATE) && !w_valid) begin
                            n_wr_code = STAT_INVALID;
                            n_failed  = 1'b1;
                            n_stlen   = '0;
                            n_state   = S_FIRST;
                        end else if (w_valid && (r_len <= q_len)) begin
                            ol_we     = 1'b1;
                            ol_wdata  = {q_off, r_len};
                            n_wr_base = q_off;
                            n_state   = S_FIRST;
                        end else begin
                            n_state = S_DECIDE;
                        end
                    end
                    default: begin
                        e_emit = 1'b1;
                        e_done = 1'b1;
                    end
                endcase
            end
            S_GETB: begin
                e_emit  = 1'b1;
                e_slot  = r_sid;
                e_byte  = pg_rdata;
                e_len   = r_slen;
                e_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SRCH: begin
                if (r_idx >= r_used) begin
                    n_snone = 1'b1;
                    n_state = S_DECIDE;
                end else if (!r_lv_q) begin
                    n_s     = r_idx[SLOT_W-1:0];
                    n_snone = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                n_need = w_need;
                n_add  = w_add;
                if (r_cmd == CMD_INSERT) begin
                    if (r_snone && (r_used >= CNT_W'(MAX_SLOTS))) begin
                        n_wr_code = STAT_FULL;
                        n_failed  = 1'b1;
                        n_wr_slot = '0;
                        n_state   = S_RD0;
                    end else if (w_fs_ok) begin
                        n_state = S_PLACE;
                    end else begin
                        n_cur       = LEN_W'(PAGE_BYTES);
                        n_have_prev = 1'b0;
                        n_state     = S_CRST;
                    end
                end else if (w_fs_ok) begin
                    n_state = S_PLACE;
                end else begin
                    n_sum   = '0;
                    n_idx   = '0;
                    n_state = S_PF;
                end
            end
            S_PF: begin
                if (r_idx >= r_used) begin
                    n_state = S_PFCHK;
                end else begin
                    if (r_lv_q && !w_skip_hit) begin
                        n_sum = r_sum + SUM_W'(q_len);
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PFCHK: begin
                if ((r_sum + SUM_W'(r_need) + SUM_W'(w_hdr_used)) <= SUM_W'(PAGE_BYTES)) begin
                    lv_we       = 1'b1;
                    n_cur       = LEN_W'(PAGE_BYTES);
                    n_have_prev = 1'b0;
                    n_state     = S_CRST;
                end else begin
                    n_wr_code = STAT_FULL;
                    n_failed  = 1'b1;
                    n_stlen   = r_valid ? r_slen : '0;
                    n_state   = S_FIRST;
                end
            end
            S_CRST: begin
                n_idx   = '0;
                n_found = 1'b0;
                n_state = S_CSCAN;
            end
            S_CSCAN: begin
                if (r_idx >= r_used) begin
                    n_state = S_CSEL;
                end else begin
                    if (w_cand && (!r_found || (q_off > r_best_off))) begin
                        n_found    = 1'b1;
                        n_best     = r_idx[SLOT_W-1:0];
                        n_best_off = q_off;
                        n_best_len = q_len;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CSEL: begin
                if (!r_found || (r_best_len > r_cur)) begin
                    n_fp    = r_cur;
                    n_state = S_POSTC;
                end else begin
                    n_cur       = w_newcur;
                    n_have_prev = 1'b1;
                    n_prev_off  = r_best_off;
                    n_prev_idx  = r_best;
                    if (r_best_off != w_newcur) begin
                        if ((({1'b0, r_best_off} + {1'b0, r_best_len})
                                <= (LEN_W+1)'(PAGE_BYTES)) && (r_best_len != '0)) begin
                            n_k     = r_best_len;
                            n_state = S_CRD;
                        end else begin
                            n_state = S_CUPD;
                        end
                    end else begin
                        n_state = S_CRST;
                    end
                end
            end
            S_CRD: begin
                pg_raddr = PAGE_AW'(r_best_off + r_k - 1'b1);
                n_state  = S_CWR;
            end
            S_CWR: begin
                pg_wr = '{we: 1'b1, addr: PAGE_AW'(r_cur + r_k - 1'b1), data: pg_rdata};
                n_k   = r_k - 1'b1;
                n_state = (r_k == LEN_W'(1)) ? S_CUPD : S_CRD;
            end
            S_CUPD: begin
                ol_we    = 1'b1;
                ol_waddr = r_best;
                ol_wdata = {r_cur, r_best_len};
                n_state  = S_CRST;
            end
            S_POSTC: begin
                if ((r_cmd != CMD_INSERT) || w_fs_ok_r) begin
                    n_state = S_PLACE;
                end else begin
                    n_wr_code = STAT_FULL;
                    n_failed  = 1'b1;
                    n_wr_slot = '0;
                    n_state   = S_RD0;
                end
            end
            S_PLACE: begin
                ol_we     = 1'b1;
                ol_waddr  = w_place_s;
                ol_wdata  = {r_fp - r_len, r_len};
                lv_we     = 1'b1;
                lv_waddr  = w_place_s;
                lv_wdata  = 1'b1;
                n_wr_slot = w_place_s;
                n_wr_base = r_fp - r_len;
                n_fp      = r_fp - r_len;
                if (r_cmd == CMD_INSERT) begin
                    if (r_snone) begin
                        n_used = r_used + 1'b1;
                    end else begin
                        n_dead = r_dead - 1'b1;
                    end
                end else if (r_cmd == CMD_RAW_WRITE) begin
                    if (r_add != '0) begin
                        n_used = CNT_W'(r_sid) + 1'b1;
                    end
                    n_dead = r_dead + r_add - (r_valid ? CNT_W'(0) : CNT_W'(1));
                end
                n_state = S_FIRST;
            end
            S_RD0: begin
                n_idx   = '0;
                n_state = S_LEN0;
            end
            S_LEN0: begin
                n_stlen = ((r_used != '0) && r_lv_q) ? q_len : '0;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                if (!r_failed && (r_cursor < r_wr_len)) begin
                    if (w_wr_addr < (LEN_W+1)'(PAGE_BYTES)) begin
                        pg_wr = '{we: 1'b1, addr: w_wr_addr[PAGE_AW-1:0], data: r_dat};
                    end
                    n_cursor = r_cursor + 1'b1;
                end
                e_emit   = 1'b1;
                e_status = r_wr_code;
                e_slot   = r_wr_slot;
                e_len    = r_failed ? r_stlen : r_wr_len;
                e_done   = r_last;
                if (r_last) begin
                    n_wr_busy = 1'b0;
                    n_cursor  = '0;
                    n_failed  = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ol_we) begin
            ol_mem[ol_waddr] <= ol_wdata;
        end
        if (lv_we) begin
            lv_mem[lv_waddr] <= lv_wdata;
        end
        r_ol_q <= ol_mem[n_idx[SLOT_W-1:0]];
        r_lv_q <= lv_mem[n_idx[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_used    <= '0;
            r_dead    <= '0;
            r_fp      <= LEN_W'(PAGE_BYTES);
            r_wr_busy <= 1'b0;
            r_cursor  <= '0;
            r_failed  <= 1'b0;
            r_wr_code <= STAT_OK;
            o_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_used    <= n_used;
            r_dead    <= n_dead;
            r_fp      <= n_fp;
            r_wr_busy <= n_wr_busy;
            r_cursor  <= n_cursor;
            r_failed  <= n_failed;
            r_wr_code <= n_wr_code;
            o_strobe  <= e_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_add <= n_add;           r_wr_base <= n_wr_base;   r_wr_len <= n_wr_len;
        r_stlen <= n_stlen;       r_wr_slot <= n_wr_slot;   r_cmd <= n_cmd;
        r_sid <= n_sid;           r_s <= n_s;               r_best <= n_best;
        r_prev_idx <= n_prev_idx; r_len <= n_len;
        r_slen <= n_slen;         r_bix <= n_bix;           r_dat <= n_dat;
        r_last <= n_last;         r_valid <= n_valid;       r_snone <= n_snone;
        r_need <= n_need;         r_sum <= n_sum;           r_cur <= n_cur;
        r_best_off <= n_best_off; r_best_len <= n_best_len; r_prev_off <= n_prev_off;
        r_k <= n_k;               r_found <= n_found;       r_have_prev <= n_have_prev;
        if (e_emit) begin
            o_status        <= e_status;
            o_result_slot   <= e_slot;
            o_read_byte     <= e_byte;
            o_stored_length <= e_len;
            o_free_bytes    <= w_free;
            o_done_res      <= e_done;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire
